>>> design/aaco_pkg.sv
// Shared constants, register indexes and payload types of the circle overlay.
package aaco_pkg;

   // Default geometry of the coordinate fields
   localparam int COORD_BITS_DEF = 12;
   localparam int FRAC_BITS_DEF  = 4;

   // Extra fractional bits carried by the blend weight
   localparam int EXTRA_BITS = 4;

   // Result bits resolved by each square-root stage
   localparam int SQRT_STEP = 3;

   // Colour channel width
   localparam int CHAN_BITS = 8;

   // Configuration register indexes
   localparam int CSR_INDEX_BITS = 3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CENTER_X = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CENTER_Y = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RADIUS   = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_INK_C0   = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_INK_C1   = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_INK_C2   = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FILL     = 3'd6;

   typedef logic [CHAN_BITS-1:0] chan_type;

   typedef struct packed {
      chan_type c0;
      chan_type c1;
      chan_type c2;
   } color_type;

   // Per-item sideband that rides along the distance pipeline
   typedef struct packed {
      color_type bg;
      logic      solid;   // inside the disk, plain ink
      logic      write;   // on the antialiased edge, blend
   } side_type;

endpackage

>>> design/aaco_if.sv
// Valid/ready channel interfaces: pixel request, pixel response, register write.
interface aaco_req_if #(
   parameter int COORD_BITS = aaco_pkg::COORD_BITS_DEF
);
   import aaco_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [COORD_BITS-1:0] pix_x;
   logic [COORD_BITS-1:0] pix_y;
   logic [CHAN_BITS-1:0]  bg_c0;
   logic [CHAN_BITS-1:0]  bg_c1;
   logic [CHAN_BITS-1:0]  bg_c2;
   modport source (output valid, pix_x, pix_y, bg_c0, bg_c1, bg_c2, input ready);
   modport sink   (input valid, pix_x, pix_y, bg_c0, bg_c1, bg_c2, output ready);
endinterface

interface aaco_rsp_if;
   import aaco_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CHAN_BITS-1:0] out_c0;
   logic [CHAN_BITS-1:0] out_c1;
   logic [CHAN_BITS-1:0] out_c2;
   logic                 touched;
   modport source (output valid, out_c0, out_c1, out_c2, touched, input ready);
   modport sink   (input valid, out_c0, out_c1, out_c2, touched, output ready);
endinterface

interface aaco_csr_if #(
   parameter int DATA_BITS = aaco_pkg::COORD_BITS_DEF + aaco_pkg::FRAC_BITS_DEF
);
   import aaco_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [DATA_BITS-1:0]      data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> design/aaco_geom.sv
// Geometry front end: box test, squared distance and ring/disk classification.
module aaco_geom #(
   parameter int COORD_BITS = aaco_pkg::COORD_BITS_DEF,
   parameter int FRAC_BITS  = aaco_pkg::FRAC_BITS_DEF,
   parameter int RAD_IN_BITS = 2 * (COORD_BITS + FRAC_BITS + aaco_pkg::EXTRA_BITS + 1)
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  logic [COORD_BITS-1:0]             pix_x,
   input  logic [COORD_BITS-1:0]             pix_y,
   input  aaco_pkg::color_type               bg,
   input  logic [COORD_BITS+FRAC_BITS-1:0]   center_x,
   input  logic [COORD_BITS+FRAC_BITS-1:0]   center_y,
   input  logic [COORD_BITS+FRAC_BITS-3:0]   radius,
   input  logic                              fill_mode,
   output logic                              out_valid,
   input  logic                              out_ready,
   output logic [RAD_IN_BITS-1:0]            out_rad,
   output aaco_pkg::side_type                out_side
);
   import aaco_pkg::*;

   localparam int POS_BITS = COORD_BITS + FRAC_BITS;
   localparam int RAD_BITS = POS_BITS - 2;
   localparam logic [POS_BITS:0] ONE_F =
      {{(POS_BITS - FRAC_BITS){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
   localparam logic [RAD_BITS:0] ONE_R =
      {{(RAD_BITS - FRAC_BITS){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};

   // Stage handshake: a stage takes a new item when empty or draining
   logic [2:0] valid_ff;
   logic [3:0] rdy;

   always_comb begin
      rdy[3] = out_ready;
      for (int s = 2; s >= 0; s--) begin
         rdy[s] = !valid_ff[s] || rdy[s+1];
      end
   end
   assign in_ready  = rdy[0];
   assign out_valid = valid_ff[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (rdy[0]) valid_ff[0] <= in_valid;
         if (rdy[1]) valid_ff[1] <= valid_ff[0];
         if (rdy[2]) valid_ff[2] <= valid_ff[1];
      end
   end

   // Stage 1: box limits and absolute offsets
   logic [POS_BITS-1:0] px, py;
   logic [POS_BITS:0]   dx, dy;
   logic [POS_BITS-1:0] adx_in, ady_in;
   logic                inbox_in;
   logic [POS_BITS-1:0] adx_ff, ady_ff;
   logic                inbox1_ff;
   color_type           bg1_ff;

   assign px = {pix_x, {FRAC_BITS{1'b0}}};
   assign py = {pix_y, {FRAC_BITS{1'b0}}};
   assign dx = {1'b0, px} - {1'b0, center_x};
   assign dy = {1'b0, py} - {1'b0, center_y};

   always_comb begin
      logic lo_x, hi_x, lo_y, hi_y;
      logic [POS_BITS:0] ndx, ndy;
      lo_x = ({1'b0, px} + {3'b000, radius} + ONE_F) > {1'b0, center_x};
      hi_x = {1'b0, px} < ({1'b0, center_x} + {3'b000, radius} + ONE_F);
      lo_y = ({1'b0, py} + {3'b000, radius} + ONE_F) > {1'b0, center_y};
      hi_y = {1'b0, py} < ({1'b0, center_y} + {3'b000, radius} + ONE_F);
      inbox_in = lo_x && hi_x && lo_y && hi_y;
      ndx = ~dx + 1'b1;
      ndy = ~dy + 1'b1;
      adx_in = dx[POS_BITS] ? ndx[POS_BITS-1:0] : dx[POS_BITS-1:0];
      ady_in = dy[POS_BITS] ? ndy[POS_BITS-1:0] : dy[POS_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         adx_ff    <= adx_in;
         ady_ff    <= ady_in;
         inbox1_ff <= inbox_in;
         bg1_ff    <= bg;
      end
   end

   // Stage 2: squares of the offsets and of the radius limits
   logic [2*POS_BITS-1:0] dxsq_ff, dysq_ff;
   logic [2*RAD_BITS-1:0] rsq_ff, rm1sq_ff;
   logic [2*RAD_BITS+1:0] rp1sq_ff;
   logic                  small_r_ff, inbox2_ff;
   color_type             bg2_ff;
   logic [RAD_BITS:0]     rp1;
   logic [RAD_BITS-1:0]   rm1;

   assign rp1 = {1'b0, radius} + ONE_R;
   assign rm1 = radius - ONE_R[RAD_BITS-1:0];

   always_ff @(posedge clock) begin
      if (rdy[1]) begin
         dxsq_ff    <= {{POS_BITS{1'b0}}, adx_ff} * {{POS_BITS{1'b0}}, adx_ff};
         dysq_ff    <= {{POS_BITS{1'b0}}, ady_ff} * {{POS_BITS{1'b0}}, ady_ff};
         rsq_ff     <= {{RAD_BITS{1'b0}}, radius} * {{RAD_BITS{1'b0}}, radius};
         rp1sq_ff   <= {{(RAD_BITS+1){1'b0}}, rp1} * {{(RAD_BITS+1){1'b0}}, rp1};
         rm1sq_ff   <= {{RAD_BITS{1'b0}}, rm1} * {{RAD_BITS{1'b0}}, rm1};
         small_r_ff <= radius < ONE_R[RAD_BITS-1:0];
         inbox2_ff  <= inbox1_ff;
         bg2_ff     <= bg1_ff;
      end
   end

   // Stage 3: squared distance, exact in/out decisions, scaled radicand
   logic [2*POS_BITS:0] d2;
   logic                le_inner, le_outer, ge_ring;
   side_type            side_in;
   logic [RAD_IN_BITS-1:0] rad_ff;
   side_type            side_ff;

   assign d2       = {1'b0, dxsq_ff} + {1'b0, dysq_ff};
   assign le_inner = d2 <= (2*POS_BITS+1)'(rsq_ff);
   assign le_outer = d2 <= (2*POS_BITS+1)'(rp1sq_ff);
   assign ge_ring  = small_r_ff || (d2 >= (2*POS_BITS+1)'(rm1sq_ff));

   always_comb begin
      side_in.bg    = bg2_ff;
      side_in.solid = 1'b0;
      side_in.write = 1'b0;
      if (inbox2_ff) begin
         if (fill_mode) begin
            side_in.solid = le_inner;
            side_in.write = !le_inner && le_outer;
         end else begin
            side_in.write = le_outer && ge_ring;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[2]) begin
         rad_ff  <= RAD_IN_BITS'({d2, {(2*EXTRA_BITS){1'b0}}});
         side_ff <= side_in;
      end
   end

   assign out_rad  = rad_ff;
   assign out_side = side_ff;

endmodule

>>> design/aaco_sqrt.sv
// Pipelined restoring square root, a few result bits per stage, sideband carried along.
module aaco_sqrt #(
   parameter int ROOT_BITS = 21
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  logic [2*ROOT_BITS-1:0]   in_rad,
   input  aaco_pkg::side_type       in_side,
   output logic                     out_valid,
   input  logic                     out_ready,
   output logic [ROOT_BITS-1:0]     out_root,
   output aaco_pkg::side_type       out_side
);
   import aaco_pkg::*;

   localparam int STAGES  = ROOT_BITS / SQRT_STEP;
   localparam int IN_BITS = 2 * ROOT_BITS;

   logic [STAGES-1:0] valid_ff;
   logic [STAGES:0]   rdy;
   logic [STAGES-1:0] valid_pre;

   logic [ROOT_BITS-1:0] root_pre [STAGES];
   logic [ROOT_BITS+1:0] rem_pre  [STAGES];
   logic [IN_BITS-1:0]   rad_pre  [STAGES];
   side_type             side_pre [STAGES];

   logic [ROOT_BITS-1:0] root_in [STAGES];
   logic [ROOT_BITS+1:0] rem_in  [STAGES];
   logic [IN_BITS-1:0]   rad_in  [STAGES];

   logic [ROOT_BITS-1:0] root_ff [STAGES];
   logic [ROOT_BITS+1:0] rem_ff  [STAGES];
   logic [IN_BITS-1:0]   rad_ff  [STAGES];
   side_type             side_ff [STAGES];

   assign rdy[STAGES] = out_ready;
   assign in_ready    = rdy[0];
   assign out_valid   = valid_ff[STAGES-1];
   assign out_root    = root_ff[STAGES-1];
   assign out_side    = side_ff[STAGES-1];

   for (genvar s = 0; s < STAGES; s++) begin : g_stage
      // Stage input: fresh radicand or previous stage's partial result
      if (s == 0) begin : g_head
         assign valid_pre[s] = in_valid;
         assign root_pre[s]  = '0;
         assign rem_pre[s]   = '0;
         assign rad_pre[s]   = in_rad;
         assign side_pre[s]  = in_side;
      end else begin : g_body
         assign valid_pre[s] = valid_ff[s-1];
         assign root_pre[s]  = root_ff[s-1];
         assign rem_pre[s]   = rem_ff[s-1];
         assign rad_pre[s]   = rad_ff[s-1];
         assign side_pre[s]  = side_ff[s-1];
      end

      assign rdy[s] = !valid_ff[s] || rdy[s+1];

      // One result bit per step: bring down two radicand bits, try root*4+1
      always_comb begin
         logic [ROOT_BITS+2:0] acc;
         logic [ROOT_BITS+2:0] trial;
         logic [ROOT_BITS-1:0] rt;
         logic [IN_BITS-1:0]   rd;
         rt  = root_pre[s];
         acc = {1'b0, rem_pre[s]};
         rd  = rad_pre[s];
         for (int k = 0; k < SQRT_STEP; k++) begin
            acc   = {acc[ROOT_BITS:0], rd[IN_BITS-1 -: 2]};
            rd    = {rd[IN_BITS-3:0], 2'b00};
            trial = {1'b0, rt, 2'b01};
            if (acc >= trial) begin
               acc = acc - trial;
               rt  = {rt[ROOT_BITS-2:0], 1'b1};
            end else begin
               rt  = {rt[ROOT_BITS-2:0], 1'b0};
            end
         end
         root_in[s] = rt;
         rem_in[s]  = acc[ROOT_BITS+1:0];
         rad_in[s]  = rd;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (rdy[s]) begin
            valid_ff[s] <= valid_pre[s];
         end
      end

      always_ff @(posedge clock) begin
         if (rdy[s]) begin
            root_ff[s] <= root_in[s];
            rem_ff[s]  <= rem_in[s];
            rad_ff[s]  <= rad_in[s];
            side_ff[s] <= side_pre[s];
         end
      end
   end

endmodule

>>> design/aaco_blend.sv
// Blend back end: edge weight from distance, per-channel mix, rounding and output register.
module aaco_blend #(
   parameter int COORD_BITS = aaco_pkg::COORD_BITS_DEF,
   parameter int FRAC_BITS  = aaco_pkg::FRAC_BITS_DEF,
   parameter int ROOT_BITS  = 21
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  logic [ROOT_BITS-1:0]              in_root,
   input  aaco_pkg::side_type                in_side,
   input  logic [COORD_BITS+FRAC_BITS-3:0]   radius,
   input  aaco_pkg::color_type               ink,
   output logic                              out_valid,
   input  logic                              out_ready,
   output aaco_pkg::color_type               out_color,
   output logic                              out_touched
);
   import aaco_pkg::*;

   localparam int WF = FRAC_BITS + EXTRA_BITS;
   localparam int PW = WF + 1 + CHAN_BITS;
   localparam logic [ROOT_BITS:0] ONE_D =
      {{(ROOT_BITS - WF){1'b0}}, 1'b1, {WF{1'b0}}};
   localparam logic [WF:0] ONE_V = {1'b1, {WF{1'b0}}};
   localparam logic [PW:0] HALF  = {{(PW - WF + 1){1'b0}}, 1'b1, {(WF-1){1'b0}}};

   // Round half up, drop the weight fraction, cap at full scale
   function automatic chan_type mix(input logic [PW-1:0] a, input logic [PW-1:0] b);
      logic [PW:0] sum;
      sum = {1'b0, a} + {1'b0, b} + HALF;
      return (sum[PW:WF] > (PW-WF+1)'(255)) ? {CHAN_BITS{1'b1}} : sum[WF+CHAN_BITS-1:WF];
   endfunction

   logic [2:0] valid_ff;
   logic [3:0] rdy;

   always_comb begin
      rdy[3] = out_ready;
      for (int s = 2; s >= 0; s--) begin
         rdy[s] = !valid_ff[s] || rdy[s+1];
      end
   end
   assign in_ready  = rdy[0];
   assign out_valid = valid_ff[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (rdy[0]) valid_ff[0] <= in_valid;
         if (rdy[1]) valid_ff[1] <= valid_ff[0];
         if (rdy[2]) valid_ff[2] <= valid_ff[1];
      end
   end

   // Stage 1: weight v = |D - r|, clamped to one
   logic [ROOT_BITS:0] rt, rq, diff;
   logic [WF:0]        v_in;
   logic [WF:0]        v_ff;
   side_type           side1_ff;

   assign rt   = {1'b0, in_root};
   assign rq   = (ROOT_BITS+1)'({radius, {EXTRA_BITS{1'b0}}});
   assign diff = (rt >= rq) ? (rt - rq) : (rq - rt);
   assign v_in = (diff > ONE_D) ? ONE_V : diff[WF:0];

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         v_ff     <= v_in;
         side1_ff <= in_side;
      end
   end

   // Stage 2: weighted background and ink products
   logic [WF:0]   w_ink;
   logic [PW-1:0] pb0_ff, pb1_ff, pb2_ff, pi0_ff, pi1_ff, pi2_ff;
   side_type      side2_ff;

   assign w_ink = ONE_V - v_ff;

   always_ff @(posedge clock) begin
      if (rdy[1]) begin
         pb0_ff   <= {{CHAN_BITS{1'b0}}, v_ff} * {{(WF+1){1'b0}}, side1_ff.bg.c0};
         pb1_ff   <= {{CHAN_BITS{1'b0}}, v_ff} * {{(WF+1){1'b0}}, side1_ff.bg.c1};
         pb2_ff   <= {{CHAN_BITS{1'b0}}, v_ff} * {{(WF+1){1'b0}}, side1_ff.bg.c2};
         pi0_ff   <= {{CHAN_BITS{1'b0}}, w_ink} * {{(WF+1){1'b0}}, ink.c0};
         pi1_ff   <= {{CHAN_BITS{1'b0}}, w_ink} * {{(WF+1){1'b0}}, ink.c1};
         pi2_ff   <= {{CHAN_BITS{1'b0}}, w_ink} * {{(WF+1){1'b0}}, ink.c2};
         side2_ff <= side1_ff;
      end
   end

   // Stage 3: final pixel select into the output register
   color_type color_in;
   color_type color_ff;
   logic      touched_ff;

   always_comb begin
      priority if (side2_ff.solid) begin
         color_in = ink;
      end else if (side2_ff.write) begin
         color_in.c0 = mix(pb0_ff, pi0_ff);
         color_in.c1 = mix(pb1_ff, pi1_ff);
         color_in.c2 = mix(pb2_ff, pi2_ff);
      end else begin
         color_in = side2_ff.bg;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[2]) begin
         color_ff   <= color_in;
         touched_ff <= side2_ff.solid || side2_ff.write;
      end
   end

   assign out_color   = color_ff;
   assign out_touched = touched_ff;

endmodule

>>> design/antialiased_circle_overlay_unit.sv
// Antialiased circle overlay: register file and pixel pipeline top level.
//
// Usage: pixels enter on req_bus (coordinates plus background colour), one
// item per clock when rsp_bus keeps ready high. Each item gives exactly one
// item on rsp_bus, in order: the overlaid colour and a touched flag.
// The circle (centre, radius, ink, ring/fill) is written over csr_bus,
// which is always ready; write it only while no pixel is in flight.
// The unit has three geometry stages (box test, squares, classification),
// the square-root stages at three result bits each, and three blend
// stages (weight, products, round and select). Throughput is one item per
// cycle while rsp_bus keeps ready high. Every stage holds its own valid
// bit; when the receiver stalls, items pack into empty stages and
// req_bus.ready drops only once the whole pipeline is full. Reset empties
// the pipeline and loads the register defaults: centre 0, radius 1.0,
// ink black, fill mode on.
module antialiased_circle_overlay_unit #(
   parameter int COORD_BITS = aaco_pkg::COORD_BITS_DEF,
   parameter int FRAC_BITS  = aaco_pkg::FRAC_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   aaco_req_if.sink    req_bus,
   aaco_rsp_if.source  rsp_bus,
   aaco_csr_if.sink    csr_bus
);
   import aaco_pkg::*;

   localparam int POS_BITS  = COORD_BITS + FRAC_BITS;
   localparam int RAD_BITS  = POS_BITS - 2;
   localparam int ROOT_MIN  = POS_BITS + EXTRA_BITS + 1;
   localparam int SQ_STAGES = (ROOT_MIN + SQRT_STEP - 1) / SQRT_STEP;
   localparam int ROOT_BITS = SQ_STAGES * SQRT_STEP;
   localparam int WF        = FRAC_BITS + EXTRA_BITS;

   // Configuration registers
   logic [POS_BITS-1:0] center_x_ff, center_y_ff;
   logic [RAD_BITS-1:0] radius_ff;
   color_type           ink_ff;
   logic                fill_ff;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff <= '0;
         center_y_ff <= '0;
         radius_ff   <= RAD_BITS'(1) << FRAC_BITS;
         ink_ff      <= '0;
         fill_ff     <= 1'b1;
      end else if (csr_bus.valid) begin
         unique case (csr_bus.index)
            CSR_CENTER_X: center_x_ff <= csr_bus.data[POS_BITS-1:0];
            CSR_CENTER_Y: center_y_ff <= csr_bus.data[POS_BITS-1:0];
            CSR_RADIUS:   radius_ff   <= csr_bus.data[RAD_BITS-1:0];
            CSR_INK_C0:   ink_ff.c0   <= csr_bus.data[CHAN_BITS-1:0];
            CSR_INK_C1:   ink_ff.c1   <= csr_bus.data[CHAN_BITS-1:0];
            CSR_INK_C2:   ink_ff.c2   <= csr_bus.data[CHAN_BITS-1:0];
            CSR_FILL:     fill_ff     <= csr_bus.data[0];
            default: ;
         endcase
      end
   end

   // Geometry front end
   color_type                 req_bg;
   logic                      g_valid, g_ready;
   logic [2*ROOT_BITS-1:0]    g_rad;
   side_type                  g_side;

   assign req_bg.c0 = req_bus.bg_c0;
   assign req_bg.c1 = req_bus.bg_c1;
   assign req_bg.c2 = req_bus.bg_c2;

   aaco_geom #(
      .COORD_BITS  (COORD_BITS),
      .FRAC_BITS   (FRAC_BITS),
      .RAD_IN_BITS (2 * ROOT_BITS)
   ) u_geom (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_bus.valid),
      .in_ready  (req_bus.ready),
      .pix_x     (req_bus.pix_x),
      .pix_y     (req_bus.pix_y),
      .bg        (req_bg),
      .center_x  (center_x_ff),
      .center_y  (center_y_ff),
      .radius    (radius_ff),
      .fill_mode (fill_ff),
      .out_valid (g_valid),
      .out_ready (g_ready),
      .out_rad   (g_rad),
      .out_side  (g_side)
   );

   // Distance square root
   logic                 s_valid, s_ready;
   logic [ROOT_BITS-1:0] s_root;
   side_type             s_side;

   aaco_sqrt #(
      .ROOT_BITS (ROOT_BITS)
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (g_valid),
      .in_ready  (g_ready),
      .in_rad    (g_rad),
      .in_side   (g_side),
      .out_valid (s_valid),
      .out_ready (s_ready),
      .out_root  (s_root),
      .out_side  (s_side)
   );

   // Blend and output register
   color_type rsp_color;

   aaco_blend #(
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS),
      .ROOT_BITS  (ROOT_BITS)
   ) u_blend (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (s_valid),
      .in_ready    (s_ready),
      .in_root     (s_root),
      .in_side     (s_side),
      .radius      (radius_ff),
      .ink         (ink_ff),
      .out_valid   (rsp_bus.valid),
      .out_ready   (rsp_bus.ready),
      .out_color   (rsp_color),
      .out_touched (rsp_bus.touched)
   );

   assign rsp_bus.out_c0 = rsp_color.c0;
   assign rsp_bus.out_c1 = rsp_color.c1;
   assign rsp_bus.out_c2 = rsp_color.c2;

   // Edge items must have a root within one pixel of the radius
   localparam logic [ROOT_BITS:0] ONE_CHK =
      {{(ROOT_BITS - WF){1'b0}}, 1'b1, {WF{1'b0}}};
   logic [ROOT_BITS:0] chk_root, chk_rq;

   assign chk_root = {1'b0, s_root};
   assign chk_rq   = (ROOT_BITS+1)'({radius_ff, {EXTRA_BITS{1'b0}}});

`ifndef SYNTHESIS
   a_ready_only_on_stall: assert property (@(posedge clock) disable iff (reset)
      !req_bus.ready |-> (rsp_bus.valid && !rsp_bus.ready))
      else $error("request side stalled without a stalled response");

   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_bus.valid)
      else $error("response valid right after reset");

   a_class_exclusive: assert property (@(posedge clock) disable iff (reset)
      g_valid |-> !(g_side.solid && g_side.write))
      else $error("pixel classed both solid and edge");

   a_root_bracket: assert property (@(posedge clock) disable iff (reset)
      (s_valid && s_side.write) |->
         ((chk_root <= chk_rq + ONE_CHK) && (chk_root + ONE_CHK >= chk_rq)))
      else $error("edge pixel distance more than one pixel off the radius");
`endif

endmodule
